@@ hw/rtl/hjc_pkg.sv @@
// Hangul jamo composer: shared types, constants and jamo lookup functions.
// Used by every module of the composer; depends on nothing.
`default_nettype none

package hjc_pkg;

  localparam int unsigned CharW             = 21;
  localparam int unsigned JamoW             = 16;
  localparam int unsigned MaxResults        = 3;
  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [CharW-1:0] JamoFirst   = 21'h003131;
  localparam logic [CharW-1:0] JamoEnd     = 21'h00314F;
  localparam logic [CharW-1:0] VowelFirst  = 21'h00314F;
  localparam logic [CharW-1:0] VowelLast   = 21'h003163;
  localparam logic [JamoW-1:0] SylBase     = 16'hAC00;
  localparam logic [8:0]       MedialCount = 9'd21;
  localparam logic [13:0]      FinalCount  = 14'd28;

  localparam logic [4:0] IniTab [30] = '{
    5'd1,  5'd2,  5'd0,  5'd3,  5'd0,  5'd0,  5'd4,  5'd5,  5'd6,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd7,  5'd8,  5'd9,  5'd0,
    5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19
  };

  localparam logic [4:0] FinTab [30] = '{
    5'd1,  5'd2,  5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd0,  5'd8,  5'd9,
    5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd0,  5'd18,
    5'd19, 5'd20, 5'd21, 5'd22, 5'd0,  5'd23, 5'd24, 5'd25, 5'd26, 5'd27
  };

  typedef enum logic [3:0] {
    PEND_NONE = 4'b0001,
    PEND_INI  = 4'b0010,
    PEND_VOW  = 4'b0100,
    PEND_FIN  = 4'b1000
  } pend_e;

  typedef struct packed {
    logic [1:0]                  last_idx;
    logic [2:0][CharW-1:0]       chars;
  } bundle_t;

  function automatic logic in_jamo(logic [CharW-1:0] c);
    return (c >= JamoFirst) && (c < JamoEnd);
  endfunction

  function automatic logic [4:0] initial_of(logic [CharW-1:0] c);
    logic [CharW-1:0] off;
    off = c - JamoFirst;
    return in_jamo(c) ? IniTab[off[4:0]] : 5'd0;
  endfunction

  function automatic logic [4:0] final_of(logic [CharW-1:0] c);
    logic [CharW-1:0] off;
    off = c - JamoFirst;
    return in_jamo(c) ? FinTab[off[4:0]] : 5'd0;
  endfunction

  function automatic logic is_vowel(logic [CharW-1:0] c);
    return (c >= VowelFirst) && (c <= VowelLast);
  endfunction

  function automatic logic [JamoW-1:0] syllable(logic [JamoW-1:0] ini,
                                                logic [JamoW-1:0] vow,
                                                logic [JamoW-1:0] fin);
    logic [4:0]       i;
    logic [JamoW-1:0] v;
    logic [8:0]       idx;
    logic [13:0]      off;
    i   = initial_of({5'b0, ini}) - 5'd1;
    v   = vow - VowelFirst[JamoW-1:0];
    idx = {4'b0, i} * MedialCount + {4'b0, v[4:0]};
    off = {5'b0, idx} * FinalCount;
    return SylBase + {2'b0, off} + {11'b0, final_of({5'b0, fin})};
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hjc_front.sv @@
// Hangul jamo composer front: accepts characters, runs the lookahead buffer
// and builds the bundle of results per request. Depends on hjc_pkg.
`default_nettype none

module hjc_front import hjc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [CharW-1:0] in_char_i,
  input  wire logic             in_end_i,
  input  wire logic             full_i,
  output logic                  push_o,
  output bundle_t               bundle_o
);

  pend_e                     pend_q, pend_d;
  logic [2:0][JamoW-1:0]     chars_q, chars_d;
  logic [2:0][CharW-1:0]     res;
  logic [2:0]                n;
  logic                      accept;
  logic                      do_start;
  logic [JamoW-1:0]          held;
  logic [CharW-1:0]          c;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign c          = in_char_i;
  assign held       = chars_q[2];

  always_comb begin
    pend_d   = pend_q;
    chars_d  = chars_q;
    res      = '0;
    n        = 3'd0;
    do_start = 1'b0;

    case (pend_q)
      PEND_NONE: begin
        do_start = 1'b1;
      end
      PEND_INI: begin
        if (is_vowel(c)) begin
          chars_d[1] = c[JamoW-1:0];
          pend_d     = PEND_VOW;
        end else begin
          res[0]   = {5'b0, chars_q[0]};
          n        = 3'd1;
          pend_d   = PEND_NONE;
          do_start = 1'b1;
        end
      end
      PEND_VOW: begin
        if (final_of(c) != 5'd0) begin
          chars_d[2] = c[JamoW-1:0];
          pend_d     = PEND_FIN;
        end else begin
          res[0]   = {5'b0, syllable(chars_q[0], chars_q[1], '0)};
          n        = 3'd1;
          pend_d   = PEND_NONE;
          do_start = 1'b1;
        end
      end
      PEND_FIN: begin
        if (is_vowel(c)) begin
          res[0] = {5'b0, syllable(chars_q[0], chars_q[1], '0)};
          if (initial_of({5'b0, held}) != 5'd0) begin
            chars_d[0] = held;
            chars_d[1] = c[JamoW-1:0];
            pend_d     = PEND_VOW;
            n          = 3'd1;
          end else begin
            res[1] = {5'b0, held};
            res[2] = c;
            n      = 3'd3;
            pend_d = PEND_NONE;
          end
        end else begin
          res[0]   = {5'b0, syllable(chars_q[0], chars_q[1], chars_q[2])};
          n        = 3'd1;
          pend_d   = PEND_NONE;
          do_start = 1'b1;
        end
      end
      default: begin
        pend_d = PEND_NONE;
      end
    endcase

    if (do_start) begin
      if (initial_of(c) != 5'd0) begin
        chars_d[0] = c[JamoW-1:0];
        pend_d     = PEND_INI;
      end else if (n < 3'd3) begin
        res[n[1:0]] = c;
        n           = n + 3'd1;
      end
    end

    if (in_end_i) begin
      if (n < 3'd3) begin
        case (pend_d)
          PEND_INI: begin
            res[n[1:0]] = {5'b0, chars_d[0]};
            n           = n + 3'd1;
          end
          PEND_VOW: begin
            res[n[1:0]] = {5'b0, syllable(chars_d[0], chars_d[1], '0)};
            n           = n + 3'd1;
          end
          PEND_FIN: begin
            res[n[1:0]] = {5'b0, syllable(chars_d[0], chars_d[1], chars_d[2])};
            n           = n + 3'd1;
          end
          default: begin
          end
        endcase
      end
      pend_d = PEND_NONE;
    end
  end

  assign push_o            = accept && (n != 3'd0);
  assign bundle_o.chars    = res;
  assign bundle_o.last_idx = 2'(n - 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PEND_NONE;
    end else if (accept) begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      chars_q <= chars_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hjc_queue.sv @@
// Hangul jamo composer queue: short FIFO of result bundles between front
// and back. Depends on hjc_pkg.
`default_nettype none

module hjc_queue import hjc_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire bundle_t bundle_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         valid_o,
  output bundle_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  bundle_t           mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= bundle_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hjc_back.sv @@
// Hangul jamo composer back: unpacks bundles into single results and drives
// the registered output channel. Depends on hjc_pkg.
`default_nettype none

module hjc_back import hjc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              head_valid_i,
  input  wire bundle_t           head_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [CharW-1:0]       out_char_o,
  output logic                   run_last_o
);

  logic [1:0]        sel_q, sel_d;
  logic              valid_q, valid_d;
  logic [CharW-1:0]  char_q;
  logic              last_q;
  logic              load;
  logic              is_last;

  assign load    = head_valid_i && (!valid_q || out_ready_i);
  assign is_last = (sel_q == head_i.last_idx);
  assign pop_o   = load && is_last;

  always_comb begin
    sel_d   = sel_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      sel_d   = is_last ? 2'd0 : sel_q + 2'd1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      sel_q   <= sel_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= head_i.chars[sel_q];
      last_q <= is_last;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = char_q;
  assign run_last_o  = last_q;

endmodule

`default_nettype wire

@@ hw/rtl/hangul_jamo_composer_core.sv @@
// Hangul jamo composer top level: front, bundle queue and back.
// Results pass the bundle queue, then the output register. Throughput: one request per
// cycle while each causes at most one result and the output is ready; k results of a
// request leave the single output register one at a time and the bundle queue absorbs
// bursts. Reset clears the lookahead state, queue pointers and output valid; held jamo
// and queue storage are not reset. Depends on hjc_pkg, hjc_front, hjc_queue, hjc_back.
`default_nettype none

module hangul_jamo_composer_core import hjc_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [CharW-1:0] in_char_i,
  input  wire logic             in_end_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [CharW-1:0]      out_char_o,
  output logic                  run_last_o
);

  logic    push;
  logic    full;
  logic    pop;
  logic    head_valid;
  bundle_t bundle;
  bundle_t head;

  hjc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_char_i  (in_char_i),
    .in_end_i   (in_end_i),
    .full_i     (full),
    .push_o     (push),
    .bundle_o   (bundle)
  );

  hjc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .full_o   (full),
    .pop_i    (pop),
    .valid_o  (head_valid),
    .head_o   (head)
  );

  hjc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_char_o   (out_char_o),
    .run_last_o   (run_last_o)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for hangul_jamo_composer_core: random and directed text streams,
// composed output predicted in-bench and compared result by result.
// Depends on hjc_pkg (CharW) and the composer RTL.

module tb;
  import hjc_pkg::CharW;

  localparam logic [CharW-1:0] JamoLo  = 21'h003131;
  localparam logic [CharW-1:0] VowelLo = 21'h00314F;
  localparam logic [CharW-1:0] VowelHi = 21'h003163;
  localparam int SylOrigin  = 'hAC00;
  localparam int TextLen    = 410;
  localparam int SettleCyc  = 20;

  localparam int IniIdx [30] = '{
    1, 2, 0, 3, 0, 0, 4, 5, 6, 0, 0, 0, 0, 0, 0,
    0, 7, 8, 9, 0, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19};
  localparam int FinIdx [30] = '{
    1, 2, 3, 4, 5, 6, 7, 0, 8, 9, 10, 11, 12, 13, 14,
    15, 16, 17, 0, 18, 19, 20, 21, 22, 0, 23, 24, 25, 26, 27};

  typedef struct packed {
    logic [CharW-1:0] cp;
    logic             eot;
  } text_item_t;

  typedef struct packed {
    logic [CharW-1:0] cp;
    logic             last;
  } composed_t;

  logic             clk_i     = 1'b0;
  logic             rst_ni    = 1'b0;
  logic             in_valid  = 1'b0;
  logic [CharW-1:0] in_char   = '0;
  logic             in_end    = 1'b0;
  logic             out_ready = 1'b0;
  logic             in_ready_o;
  logic             out_valid_o;
  logic [CharW-1:0] out_char_o;
  logic             run_last_o;

  text_item_t       text_q [$];
  text_item_t       next_item;
  composed_t        composed_q [$];
  composed_t        want;
  logic [CharW-1:0] step_out [$];
  logic [CharW-1:0] held_cp [3];
  int               held_n;
  int               chars_taken;
  int               text_total;
  int               mismatches;
  int               in_wait;
  int               out_wait;
  bit               calm_in;
  bit               calm_out;

  hangul_jamo_composer_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_char_i   (in_char),
    .in_end_i    (in_end),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_char_o  (out_char_o),
    .run_last_o  (run_last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int ini_of(logic [CharW-1:0] c);
    if (c < JamoLo || c >= JamoLo + 30) return 0;
    return IniIdx[c - JamoLo];
  endfunction

  function automatic int fin_of(logic [CharW-1:0] c);
    if (c < JamoLo || c >= JamoLo + 30) return 0;
    return FinIdx[c - JamoLo];
  endfunction

  function automatic bit vowel(logic [CharW-1:0] c);
    return c >= VowelLo && c <= VowelHi;
  endfunction

  function automatic logic [CharW-1:0] make_syllable(logic [CharW-1:0] ini,
                                                     logic [CharW-1:0] vow,
                                                     logic [CharW-1:0] fin);
    int lead;
    int med;
    lead = ini_of(ini) - 1;
    med  = int'(vow - VowelLo);
    return CharW'(SylOrigin + 28 * (21 * lead + med) + fin_of(fin));
  endfunction

  function automatic int gap_len(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // hold an initial consonant, pass anything else
  task automatic open_or_pass(input logic [CharW-1:0] c);
    if (ini_of(c) != 0) begin
      held_cp[0] = c;
      held_n     = 1;
    end else begin
      step_out.push_back(c);
    end
  endtask

  task automatic compose_char(input logic [CharW-1:0] c, input logic eot);
    logic [CharW-1:0] prev;
    composed_t        res;
    step_out.delete();
    case (held_n)
      0: open_or_pass(c);
      1: begin
        if (vowel(c)) begin
          held_cp[1] = c;
          held_n     = 2;
        end else begin
          step_out.push_back(held_cp[0]);
          held_n = 0;
          open_or_pass(c);
        end
      end
      2: begin
        if (fin_of(c) != 0) begin
          held_cp[2] = c;
          held_n     = 3;
        end else begin
          step_out.push_back(make_syllable(held_cp[0], held_cp[1], '0));
          held_n = 0;
          open_or_pass(c);
        end
      end
      default: begin
        if (vowel(c)) begin
          prev = held_cp[2];
          step_out.push_back(make_syllable(held_cp[0], held_cp[1], '0));
          if (ini_of(prev) != 0) begin
            held_cp[0] = prev;
            held_cp[1] = c;
            held_n     = 2;
          end else begin
            step_out.push_back(prev);
            step_out.push_back(c);
            held_n = 0;
          end
        end else begin
          step_out.push_back(make_syllable(held_cp[0], held_cp[1], held_cp[2]));
          held_n = 0;
          open_or_pass(c);
        end
      end
    endcase
    if (eot) begin
      if (held_n == 1) step_out.push_back(held_cp[0]);
      else if (held_n == 2) step_out.push_back(make_syllable(held_cp[0], held_cp[1], '0));
      else if (held_n == 3)
        step_out.push_back(make_syllable(held_cp[0], held_cp[1], held_cp[2]));
      held_n = 0;
    end
    for (int k = 0; k < step_out.size(); k++) begin
      res.cp   = step_out[k];
      res.last = (k == step_out.size() - 1);
      composed_q.push_back(res);
    end
  endtask

  task automatic add_char(input logic [CharW-1:0] c, input logic eot);
    text_item_t it;
    it.cp  = c;
    it.eot = eot;
    text_q.push_back(it);
  endtask

  task automatic mark_end();
    text_item_t it;
    it     = text_q.pop_back();
    it.eot = 1'b1;
    text_q.push_back(it);
  endtask

  function automatic logic [CharW-1:0] pick_initial();
    int k;
    do k = $urandom_range(0, 29); while (IniIdx[k] == 0);
    return JamoLo + CharW'(k);
  endfunction

  function automatic logic [CharW-1:0] pick_final();
    int k;
    do k = $urandom_range(0, 29); while (FinIdx[k] == 0);
    return JamoLo + CharW'(k);
  endfunction

  function automatic logic [CharW-1:0] pick_vowel();
    return CharW'($urandom_range(VowelLo, VowelHi));
  endfunction

  function automatic logic [CharW-1:0] noise_char();
    case ($urandom_range(0, 4))
      0: return CharW'($urandom);
      1: return CharW'($urandom_range(0, 127));
      2: return CharW'($urandom_range('h3130, 'h3164));
      3: begin
        case ($urandom_range(0, 7))
          0: return 21'h003130;
          1: return 21'h00314E;
          2: return 21'h003164;
          3: return 21'h00AC00;
          4: return 21'h00D7A3;
          5: return 21'h10FFFF;
          6: return 21'h110000;
          default: return 21'h1FFFFF;
        endcase
      end
      default: return CharW'($urandom_range('h110000, 'h1FFFFF));
    endcase
  endfunction

  // driver: hold each request until taken, random gaps between requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_char  <= '0;
      in_end   <= 1'b0;
      in_wait  = 0;
    end else if (!in_valid || in_ready_o) begin
      if (in_wait > 0) begin
        in_valid <= 1'b0;
        in_wait--;
      end else if (text_q.size() != 0) begin
        next_item = text_q.pop_front();
        in_valid <= 1'b1;
        in_char  <= next_item.cp;
        in_end   <= next_item.eot;
        if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
        in_wait = gap_len(calm_in);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: predict on every accepted request, check every accepted result
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_wait  = 0;
      held_n    = 0;
    end else begin
      if (in_valid && in_ready_o) begin
        compose_char(in_char, in_end);
        chars_taken++;
      end
      if (out_valid_o && out_ready) begin
        if (composed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result char %h last %b", $time, out_char_o, run_last_o);
        end else begin
          want = composed_q.pop_front();
          if (out_char_o !== want.cp || run_last_o !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: char exp %h got %h, last exp %b got %b", $time,
                       want.cp, out_char_o, want.last, run_last_o);
          end
        end
      end
      if (out_wait > 0) begin
        out_ready <= 1'b0;
        out_wait--;
      end else begin
        out_ready <= 1'b1;
        if (out_valid_o && out_ready) begin
          if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
          out_wait = gap_len(calm_out);
        end
      end
    end
  end

  initial begin
    chars_taken = 0;
    mismatches  = 0;
    calm_in     = 1'b0;
    calm_out    = 1'b0;

    add_char(21'h000000, 1'b0);
    add_char(21'h1FFFFF, 1'b0);
    add_char(21'h10FFFF, 1'b0);
    add_char(21'h00314F, 1'b0);
    add_char(21'h003131, 1'b0);
    add_char(21'h00314F, 1'b0);
    add_char(21'h003131, 1'b0);
    add_char(21'h003163, 1'b0);
    add_char(21'h000041, 1'b1);
    add_char(21'h00314E, 1'b0);
    add_char(21'h003163, 1'b0);
    add_char(21'h003133, 1'b0);
    add_char(21'h00314F, 1'b0);
    add_char(21'h003131, 1'b0);
    add_char(21'h00314F, 1'b0);
    add_char(21'h00314E, 1'b1);
    add_char(21'h00314E, 1'b1);
    add_char(21'h003131, 1'b0);
    add_char(21'h003163, 1'b1);
    add_char(21'h003131, 1'b0);
    add_char(21'h003133, 1'b1);

    while (text_q.size() < TextLen) begin
      if ($urandom_range(0, 99) < 70) begin
        add_char(pick_initial(), 1'b0);
        if ($urandom_range(0, 9) != 0) add_char(pick_vowel(), 1'b0);
        if ($urandom_range(0, 1) != 0) add_char(pick_final(), 1'b0);
        if ($urandom_range(0, 3) == 0) add_char(pick_vowel(), 1'b0);
      end else begin
        add_char(noise_char(), 1'b0);
      end
      if ($urandom_range(0, 7) == 0) mark_end();
    end
    mark_end();
    text_total = text_q.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (chars_taken != text_total) @(posedge clk_i);
    while (composed_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);

    if (mismatches == 0 && composed_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
